// File: hdl/dqr_pkg.sv
// ---------------------------------------------------------------------------
// Deque with reverse: shared definitions
// Word widths, mode and status codes, and controller states used by the
// deque and its port checker.
// ---------------------------------------------------------------------------
package dqr_pkg;

  localparam int DQR_CAPACITY = 64;
  localparam int DATA_W       = 32;
  localparam int MODE_W       = 3;
  localparam int STATUS_W     = 2;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH_FRONT = 3'd0,
    MODE_PUSH_BACK  = 3'd1,
    MODE_POP_FRONT  = 3'd2,
    MODE_POP_BACK   = 3'd3,
    MODE_SHOW       = 3'd4,
    MODE_REVERSE    = 3'd5
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_RESP
  } state_t;

endpackage

// File: hdl/deque_with_reverse.sv
// ---------------------------------------------------------------------------
// Deque with reverse
// Bounded double-ended queue of signed words kept in a ring memory with a
// front pointer, an occupancy count and a direction flag.
// ---------------------------------------------------------------------------
// Push, reverse and unused modes need no memory read. A push and any refused
// or empty request give one result word, which waits in the result holder
// while the output register is full. Pop issues the memory read when
// accepted; S_WALK hands the read word on. Show makes one memory read per
// element, pipelined. A word sits in the output register until taken; stall
// on the output only holds the block when the output register is still full.
// Synchronous active-low reset empties the deque and clears the direction
// flag; memory contents are not cleared, since empty entries are never read.
module deque_with_reverse #(
  parameter int CAPACITY = dqr_pkg::DQR_CAPACITY
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [dqr_pkg::MODE_W-1:0]          in_mode,
  input  logic signed [dqr_pkg::DATA_W-1:0]   in_value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [dqr_pkg::STATUS_W-1:0]        out_status,
  output logic signed [dqr_pkg::DATA_W-1:0]   out_item,
  output logic                                out_last
);
  import dqr_pkg::*;

  localparam int PW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [PW-1:0] TOP_ADDR = PW'(CAPACITY - 1);

  logic signed [DATA_W-1:0] mem [CAPACITY];

  state_t                   state_r, state_nxt;
  logic [PW-1:0]            fp_r, fp_nxt;
  logic [CW-1:0]            occ_r, occ_nxt;
  logic                     rev_r, rev_nxt;
  logic [PW-1:0]            addr_r, addr_nxt;
  logic [CW-1:0]            remain_r, remain_nxt;
  status_t                  res_status_r, res_status_nxt;
  logic signed [DATA_W-1:0] res_item_r, res_item_nxt;
  logic                     out_valid_r, out_valid_nxt;
  status_t                  out_status_r, out_status_nxt;
  logic signed [DATA_W-1:0] out_item_r, out_item_nxt;
  logic                     out_last_r, out_last_nxt;
  logic signed [DATA_W-1:0] rd_data_r;

  logic                     mem_we;
  logic [PW-1:0]            mem_wa;
  logic signed [DATA_W-1:0] mem_wd;
  logic                     rd_en;
  logic [PW-1:0]            rd_addr;

  logic                     out_free;
  logic                     full, empty;
  logic [PW-1:0]            head_dec, head_inc, walk_inc, walk_dec;
  logic [CW:0]              sum_tail, sum_back;
  logic [PW-1:0]            tail_addr, back_addr;

  assign in_stall   = (state_r != S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_item   = out_item_r;
  assign out_last   = out_last_r;

  assign out_free = !out_valid_r || !out_stall;
  assign full     = (occ_r >= CW'(CAPACITY));
  assign empty    = (occ_r == '0);

  // Ring arithmetic; sums stay below twice the capacity, so one subtract wraps.
  assign head_dec  = (fp_r == '0) ? TOP_ADDR : fp_r - 1'b1;
  assign head_inc  = (fp_r == TOP_ADDR) ? '0 : fp_r + 1'b1;
  assign walk_dec  = (addr_r == '0) ? TOP_ADDR : addr_r - 1'b1;
  assign walk_inc  = (addr_r == TOP_ADDR) ? '0 : addr_r + 1'b1;
  assign sum_tail  = (CW+1)'(fp_r) + (CW+1)'(occ_r);
  assign sum_back  = sum_tail - 1'b1;
  assign tail_addr = (sum_tail >= (CW+1)'(CAPACITY)) ?
                     PW'(sum_tail - (CW+1)'(CAPACITY)) : PW'(sum_tail);
  assign back_addr = (sum_back >= (CW+1)'(CAPACITY)) ?
                     PW'(sum_back - (CW+1)'(CAPACITY)) : PW'(sum_back);

  always_comb begin
    logic                     r_send;
    status_t                  r_status;
    logic signed [DATA_W-1:0] r_item;
    logic                     at_head;

    state_nxt      = state_r;
    fp_nxt         = fp_r;
    occ_nxt        = occ_r;
    rev_nxt        = rev_r;
    addr_nxt       = addr_r;
    remain_nxt     = remain_r;
    res_status_nxt = res_status_r;
    res_item_nxt   = res_item_r;
    out_status_nxt = out_status_r;
    out_item_nxt   = out_item_r;
    out_last_nxt   = out_last_r;
    out_valid_nxt  = out_valid_r && out_stall;
    mem_we         = 1'b0;
    mem_wa         = fp_r;
    mem_wd         = in_value;
    rd_en          = 1'b0;
    rd_addr        = fp_r;
    r_send         = 1'b0;
    r_status       = ST_OK;
    r_item         = '0;
    at_head        = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          case (mode_t'(in_mode))
            MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
              r_send = 1'b1;
              if (full) begin
                r_status = ST_FULL;
              end else begin
                at_head  = (mode_t'(in_mode) == MODE_PUSH_FRONT) ^ rev_r;
                mem_we   = 1'b1;
                mem_wa   = at_head ? head_dec : tail_addr;
                if (at_head) begin
                  fp_nxt = head_dec;
                end
                occ_nxt  = occ_r + 1'b1;
                r_item   = in_value;
              end
            end
            MODE_POP_FRONT, MODE_POP_BACK: begin
              if (empty) begin
                r_send   = 1'b1;
                r_status = ST_EMPTY;
              end else begin
                at_head    = (mode_t'(in_mode) == MODE_POP_FRONT) ^ rev_r;
                rd_en      = 1'b1;
                rd_addr    = at_head ? fp_r : back_addr;
                addr_nxt   = rd_addr;
                if (at_head) begin
                  fp_nxt = head_inc;
                end
                occ_nxt    = occ_r - 1'b1;
                remain_nxt = CW'(1);
                state_nxt  = S_WALK;
              end
            end
            MODE_SHOW: begin
              if (empty) begin
                r_send   = 1'b1;
                r_status = ST_EMPTY;
              end else begin
                rd_en      = 1'b1;
                rd_addr    = rev_r ? back_addr : fp_r;
                addr_nxt   = rd_addr;
                remain_nxt = occ_r;
                state_nxt  = S_WALK;
              end
            end
            MODE_REVERSE: begin
              rev_nxt = ~rev_r;
            end
            default: begin
            end
          endcase
        end
        // Single-word results go straight out, or wait in the result holder.
        if (r_send) begin
          if (out_free) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = r_status;
            out_item_nxt   = r_item;
            out_last_nxt   = 1'b1;
          end else begin
            res_status_nxt = r_status;
            res_item_nxt   = r_item;
            state_nxt      = S_RESP;
          end
        end
      end
      S_WALK: begin
        // rd_data_r holds the word at addr_r; it only changes on a new read.
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_OK;
          out_item_nxt   = rd_data_r;
          out_last_nxt   = (remain_r == CW'(1));
          if (remain_r == CW'(1)) begin
            state_nxt = S_IDLE;
          end else begin
            rd_en      = 1'b1;
            rd_addr    = rev_r ? walk_dec : walk_inc;
            addr_nxt   = rd_addr;
            remain_nxt = remain_r - 1'b1;
          end
        end
      end
      S_RESP: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_item_nxt   = res_item_r;
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fp_r        <= '0;
      occ_r       <= '0;
      rev_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fp_r        <= fp_nxt;
      occ_r       <= occ_nxt;
      rev_r       <= rev_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r       <= addr_nxt;
    remain_r     <= remain_nxt;
    res_status_r <= res_status_nxt;
    res_item_r   <= res_item_nxt;
    out_status_r <= out_status_nxt;
    out_item_r   <= out_item_nxt;
    out_last_r   <= out_last_nxt;
  end

  // Writes and reads never fall in the same cycle, and a read issued the
  // cycle after a write already sees the written word, so no bypass is needed.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule

// File: hdl/dqr_checker.sv
// ---------------------------------------------------------------------------
// Deque with reverse: port checker
// Watches the ports of the deque and flags result words that break its
// rules; attached to the top level by the bind below.
// ---------------------------------------------------------------------------
module dqr_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_stall,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic [dqr_pkg::STATUS_W-1:0]      out_status,
  input logic signed [dqr_pkg::DATA_W-1:0] out_item,
  input logic                              out_last
);
  import dqr_pkg::*;

  // A word held by stall stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) &&
                               $stable(out_item) && $stable(out_last))
    else $error("result word changed while stalled");

  // Refused or empty requests give a single word.
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_OK) |-> out_last)
    else $error("error status without last");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_OK) |-> (out_item == '0))
    else $error("error status with nonzero item");

  // Reset empties the output and frees the input.
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("reset left the block busy");

endmodule

bind deque_with_reverse dqr_checker u_dqr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .out_status (out_status),
  .out_item   (out_item),
  .out_last   (out_last)
);

// File: tb/deque_with_reverse_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Deque with reverse: testbench
// Sends directed and random push, pop, show and reverse words in bursts
// while the output side stalls on its own pattern. Every result word is
// compared in order against a behavioral copy of the deque held in a small
// scoreboard. The scoreboard covers the ring, the front pointer, the
// occupancy and the direction flag.
// ---------------------------------------------------------------------------
module deque_with_reverse_tb;
  import dqr_pkg::*;

  localparam int DEPTH       = DQR_CAPACITY;
  localparam int N_ITEMS     = 380;
  localparam int IDLE_LIMIT  = 2000;
  localparam int MAX_REPORTS = 10;

  localparam logic [MODE_W-1:0] MODE_UNUSED_6 = 3'd6;
  localparam logic [MODE_W-1:0] MODE_UNUSED_7 = 3'd7;

  typedef struct {
    status_t                  status;
    logic signed [DATA_W-1:0] item;
    logic                     last;
  } deque_result_t;

  class deque_tracker;
    logic signed [DATA_W-1:0] ring [DEPTH];
    int unsigned              head = 0;
    int unsigned              count = 0;
    bit                       flipped = 1'b0;
    deque_result_t            awaited [$];
    int unsigned              fault_count = 0;

    function void flag(string msg);
      fault_count++;
      if (fault_count <= MAX_REPORTS) begin
        $display("%0t: %s", $time, msg);
      end
    endfunction

    function void queue_result(status_t st, logic signed [DATA_W-1:0] it, logic lst);
      deque_result_t r;
      r.status = st;
      r.item   = it;
      r.last   = lst;
      awaited.push_back(r);
    endfunction

    function bit busy();
      return awaited.size() != 0;
    endfunction

    // Works out the result words of one accepted input word.
    function void note_word(logic [MODE_W-1:0] m, logic signed [DATA_W-1:0] v);
      bit                       at_head;
      logic signed [DATA_W-1:0] w;
      int unsigned              k;
      case (m)
        MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
          if (count >= DEPTH) begin
            queue_result(ST_FULL, '0, 1'b1);
          end else begin
            // The logical front is the physical head unless reversed.
            at_head = (m == MODE_PUSH_FRONT) ^ flipped;
            if (at_head) begin
              head = (head + DEPTH - 1) % DEPTH;
              ring[head] = v;
            end else begin
              ring[(head + count) % DEPTH] = v;
            end
            count++;
            queue_result(ST_OK, v, 1'b1);
          end
        end
        MODE_POP_FRONT, MODE_POP_BACK: begin
          if (count == 0) begin
            queue_result(ST_EMPTY, '0, 1'b1);
          end else begin
            at_head = (m == MODE_POP_FRONT) ^ flipped;
            if (at_head) begin
              w = ring[head];
              head = (head + 1) % DEPTH;
            end else begin
              w = ring[(head + count - 1) % DEPTH];
            end
            count--;
            queue_result(ST_OK, w, 1'b1);
          end
        end
        MODE_SHOW: begin
          if (count == 0) begin
            queue_result(ST_EMPTY, '0, 1'b1);
          end else begin
            for (int unsigned i = 0; i < count; i++) begin
              k = flipped ? (count - 1 - i) : i;
              queue_result(ST_OK, ring[(head + k) % DEPTH], i == count - 1);
            end
          end
        end
        MODE_REVERSE: begin
          flipped = !flipped;
        end
        default: begin
        end
      endcase
    endfunction

    function void check_word(logic [STATUS_W-1:0] st, logic signed [DATA_W-1:0] it,
                             logic lst);
      deque_result_t e;
      if (awaited.size() == 0) begin
        flag($sformatf("result word with none awaited: status %0d item %0d last %0b",
                       st, it, lst));
        return;
      end
      e = awaited.pop_front();
      if (st !== e.status || it !== e.item || lst !== e.last) begin
        flag($sformatf({"result mismatch: expected status %0d item %0d last %0b, ",
                        "got status %0d item %0d last %0b"},
                       e.status, e.item, e.last, st, it, lst));
      end
    endfunction
  endclass

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_stall;
  logic [MODE_W-1:0]        in_mode;
  logic signed [DATA_W-1:0] in_value;
  logic                     out_valid;
  logic                     out_stall;
  logic [STATUS_W-1:0]      out_status;
  logic signed [DATA_W-1:0] out_item;
  logic                     out_last;

  deque_tracker tracker = new;
  int           idle_cycles = 0;
  int           burst_left = 0;
  int           sent = 0;
  int           level = 0;

  deque_with_reverse #(
    .CAPACITY(DEPTH)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_mode   (in_mode),
    .in_value  (in_value),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_status(out_status),
    .out_item  (out_item),
    .out_last  (out_last)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Results are checked before the input of the same edge is noted, since
  // no result can come from a word accepted at that very edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        tracker.check_word(out_status, out_item, out_last);
      end
      if (in_valid && !in_stall) begin
        tracker.note_word(in_mode, in_value);
      end
      if ((out_valid && !out_stall) || (in_valid && !in_stall)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    while (idle_cycles < IDLE_LIMIT) @(posedge clk);
    $display("DONE: errors detected");
    $finish;
  end

  // Output stall: stretches that are free, lightly stalled or heavily stalled.
  initial begin
    int style;
    int span;
    out_stall <= 1'b0;
    forever begin
      style = $urandom_range(0, 2);
      span  = $urandom_range(20, 80);
      repeat (span) begin
        @(posedge clk);
        case (style)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(0, 2) == 0);
          default: out_stall <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2:       return '0;
      3:       return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [MODE_W-1:0] pick_mode();
    int r;
    r = $urandom_range(0, 39);
    if (r < 9)  return MODE_PUSH_FRONT;
    if (r < 18) return MODE_PUSH_BACK;
    if (r < 26) return MODE_POP_FRONT;
    if (r < 34) return MODE_POP_BACK;
    if (r < 36) return MODE_SHOW;
    if (r < 38) return MODE_REVERSE;
    if (r < 39) return MODE_UNUSED_6;
    return MODE_UNUSED_7;
  endfunction

  function automatic logic [MODE_W-1:0] pick_push();
    return $urandom_range(0, 1) ? MODE_PUSH_BACK : MODE_PUSH_FRONT;
  endfunction

  function automatic logic [MODE_W-1:0] pick_pop();
    return $urandom_range(0, 1) ? MODE_POP_BACK : MODE_POP_FRONT;
  endfunction

  // Sends one word; the sender runs in bursts with random gaps in between.
  task automatic issue(input logic [MODE_W-1:0] m, input logic signed [DATA_W-1:0] v);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
                                               : $urandom_range(1, 10);
    end
    in_valid <= 1'b1;
    in_mode  <= m;
    in_value <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    burst_left--;
    case (m)
      MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
        sent++;
        if (level < DEPTH) level++;
      end
      MODE_POP_FRONT, MODE_POP_BACK: begin
        sent++;
        if (level > 0) level--;
      end
      MODE_SHOW, MODE_REVERSE: sent++;
      default: begin
      end
    endcase
  endtask

  // Holds the sender off until every awaited result word has arrived.
  task automatic settle();
    in_valid   <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (tracker.busy()) @(posedge clk);
  endtask

  initial begin
    int r;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_mode  <= MODE_PUSH_FRONT;
    in_value <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Empty store first, then the value extremes in both directions.
    issue(MODE_SHOW, '0);
    issue(MODE_POP_FRONT, '0);
    issue(MODE_POP_BACK, '0);
    issue(MODE_UNUSED_6, 32'sh7FFF_FFFF);
    issue(MODE_UNUSED_7, 32'sh8000_0000);
    issue(MODE_PUSH_FRONT, 32'sh7FFF_FFFF);
    issue(MODE_PUSH_BACK, 32'sh8000_0000);
    issue(MODE_PUSH_FRONT, -32'sd1);
    issue(MODE_PUSH_BACK, '0);
    issue(MODE_SHOW, '0);
    issue(MODE_REVERSE, '0);
    issue(MODE_SHOW, '0);
    issue(MODE_PUSH_FRONT, 32'sh5555_5555);
    issue(MODE_PUSH_BACK, 32'shAAAA_AAAA);
    issue(MODE_POP_FRONT, '0);
    issue(MODE_POP_BACK, '0);
    issue(MODE_REVERSE, '0);
    issue(MODE_POP_BACK, '0);
    issue(MODE_POP_FRONT, '0);
    issue(MODE_SHOW, '0);
    issue(MODE_POP_FRONT, '0);
    issue(MODE_POP_BACK, '0);
    issue(MODE_POP_FRONT, '0);
    issue(MODE_SHOW, '0);
    settle();

    while (sent < N_ITEMS) begin
      case ($urandom_range(0, 3))
        0: begin
          // Fill to capacity, then push against the full store.
          while (level < DEPTH) begin
            r = $urandom_range(0, 39);
            if (r == 0) issue(MODE_REVERSE, pick_value());
            else if (r == 1) issue(MODE_SHOW, pick_value());
            else issue(pick_push(), pick_value());
          end
          repeat ($urandom_range(1, 3)) issue(pick_push(), pick_value());
          if ($urandom_range(0, 1)) issue(MODE_SHOW, pick_value());
        end
        1: begin
          // Drain to empty, then pop and show the empty store.
          while (level > 0) begin
            if ($urandom_range(0, 19) == 0) issue(MODE_REVERSE, pick_value());
            else issue(pick_pop(), pick_value());
          end
          repeat ($urandom_range(1, 2)) issue(pick_pop(), pick_value());
          issue(MODE_SHOW, pick_value());
        end
        2: begin
          repeat ($urandom_range(15, 40)) issue(pick_mode(), pick_value());
        end
        default: begin
          // Short deque with frequent shows and turns.
          repeat ($urandom_range(8, 16)) begin
            r = $urandom_range(0, 9);
            if (r < 2) issue(MODE_SHOW, pick_value());
            else if (r == 2) issue(MODE_REVERSE, pick_value());
            else if (level < 3 || r < 6) issue(pick_push(), pick_value());
            else issue(pick_pop(), pick_value());
          end
        end
      endcase
      if ($urandom_range(0, 3) == 0) settle();
    end

    settle();
    repeat (2 * DEPTH + 20) @(posedge clk);
    if (tracker.busy()) begin
      tracker.flag($sformatf("%0d result words never arrived", tracker.awaited.size()));
    end
    if (tracker.fault_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
